// File: rtl/vlpd_pkg.sv
// Shared types and constants for the varint length-prefix deframer.
// No dependencies; used by the top level and its checker.
package vlpd_pkg;

   // Result codes on rsp_kind
   typedef enum logic [1:0] {
      KIND_PAYLOAD   = 2'd0,
      KIND_EMPTY     = 2'd1,
      KIND_OVERLONG  = 2'd2,
      KIND_TOO_LARGE = 2'd3
   } kind_type;

   localparam int unsigned LEN_W          = 32;
   localparam int unsigned CNT_W          = 4;
   localparam logic [CNT_W-1:0] MAX_VARINT_BYTES = CNT_W'(10);
   localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = LEN_W'(1024);

   // Bit positions inside a length byte
   localparam int unsigned CONT_BIT   = 7;
   localparam int unsigned GROUP_BITS = 7;

endpackage

// File: rtl/varint_length_prefix_deframer.sv
// Top level of the varint length-prefix deframer.
// Depends on vlpd_pkg (result codes, widths, reset values).

// Takes one byte of a stream per transfer and splits it into messages, each
// a varint length (7-bit groups, low group first, bit 7 = more to come)
// followed by that many payload bytes. Every payload byte comes out as a
// kind 0 result, with last set on the final byte of the message. A zero
// length gives one kind 1 result (last set). A varint still continued at its
// tenth byte gives kind 2; a length above csr_wr_data's register (max_length,
// reset 1024) gives kind 3; after either, decoding restarts with the next
// byte. Bits of the length above bit 31 are dropped. Length bytes that give
// no result are consumed silently. Throughput is one byte per clock: each
// byte passes through a single stage of decode logic into the result
// register, and a new byte is taken whenever that register is empty or being
// drained in the same cycle. Results are registered and appear in the cycle
// after the byte transfer. max_length must be written through csr_wr_en /
// csr_wr_data only while the block is idle; the block does not enforce it.
module varint_length_prefix_deframer (
   input  logic                        clock,
   input  logic                        reset,
   // input byte channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_byte_in,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_kind,
   output logic [7:0]                  rsp_data,
   output logic                        rsp_last,
   // configuration: max_length
   input  logic                        csr_wr_en,
   input  logic [vlpd_pkg::LEN_W-1:0]  csr_wr_data
);

   localparam int unsigned LW = vlpd_pkg::LEN_W;
   localparam int unsigned CW = vlpd_pkg::CNT_W;

   // running decode state
   logic          in_payload_ff,  in_payload_in;
   logic [LW-1:0] accum_ff,       accum_in;
   logic [CW-1:0] byte_count_ff,  byte_count_in;
   logic [LW-1:0] remaining_ff,   remaining_in;
   logic [LW-1:0] max_length_ff;

   // result register
   logic          rsp_valid_ff,   rsp_valid_in;
   logic [1:0]    rsp_kind_ff,    rsp_kind_in;
   logic [7:0]    rsp_data_ff,    rsp_data_in;
   logic          rsp_last_ff,    rsp_last_in;

   logic          req_xfer;
   logic          has_result;
   logic [LW-1:0] group;
   logic [LW-1:0] accum_new;
   logic [CW-1:0] count_inc;
   logic          final_byte;

   // Result register is the only buffer: refill it when empty or draining.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_last  = rsp_last_ff;

   // Weight of the current length byte; fifth byte keeps only its low nibble.
   always_comb begin
      group = '0;
      unique case (byte_count_ff)
         CW'(0): group = LW'(req_byte_in[6:0]);
         CW'(1): group = LW'(req_byte_in[6:0]) << (1 * vlpd_pkg::GROUP_BITS);
         CW'(2): group = LW'(req_byte_in[6:0]) << (2 * vlpd_pkg::GROUP_BITS);
         CW'(3): group = LW'(req_byte_in[6:0]) << (3 * vlpd_pkg::GROUP_BITS);
         CW'(4): group = {req_byte_in[3:0], {(LW-4){1'b0}}};
         default: group = '0;
      endcase
   end

   assign accum_new  = accum_ff | group;
   assign count_inc  = byte_count_ff + CW'(1);
   assign final_byte = (remaining_ff[LW-1:1] == '0);

   always_comb begin
      in_payload_in = in_payload_ff;
      accum_in      = accum_ff;
      byte_count_in = byte_count_ff;
      remaining_in  = remaining_ff;
      has_result    = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;

      if (req_xfer) begin
         if (in_payload_ff) begin
            has_result  = 1'b1;
            rsp_kind_in = vlpd_pkg::KIND_PAYLOAD;
            rsp_data_in = req_byte_in;
            rsp_last_in = final_byte;
            if (final_byte) begin
               remaining_in  = '0;
               in_payload_in = 1'b0;
               accum_in      = '0;
               byte_count_in = '0;
            end else begin
               remaining_in = remaining_ff - LW'(1);
            end
         end else begin
            rsp_data_in = '0;
            rsp_last_in = 1'b0;
            accum_in      = accum_new;
            byte_count_in = count_inc;
            priority if (req_byte_in[vlpd_pkg::CONT_BIT]) begin
               if (count_inc >= vlpd_pkg::MAX_VARINT_BYTES) begin
                  has_result    = 1'b1;
                  rsp_kind_in   = vlpd_pkg::KIND_OVERLONG;
                  accum_in      = '0;
                  byte_count_in = '0;
               end
            end else if (accum_new == '0) begin
               has_result    = 1'b1;
               rsp_kind_in   = vlpd_pkg::KIND_EMPTY;
               rsp_last_in   = 1'b1;
               accum_in      = '0;
               byte_count_in = '0;
            end else if (accum_new > max_length_ff) begin
               // resync: what follows is parsed as a new length
               has_result    = 1'b1;
               rsp_kind_in   = vlpd_pkg::KIND_TOO_LARGE;
               accum_in      = '0;
               byte_count_in = '0;
            end else begin
               remaining_in  = accum_new;
               accum_in      = '0;
               byte_count_in = '0;
               in_payload_in = 1'b1;
            end
         end
      end

      // hold, load or drain the result register
      if (req_xfer) begin
         rsp_valid_in = has_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff <= 1'b0;
         accum_ff      <= '0;
         byte_count_ff <= '0;
         remaining_ff  <= '0;
         max_length_ff <= vlpd_pkg::MAX_LENGTH_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_payload_ff <= in_payload_in;
         accum_ff      <= accum_in;
         byte_count_ff <= byte_count_in;
         remaining_ff  <= remaining_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            max_length_ff <= csr_wr_data;
         end
      end
   end

   // payload of the result register, no reset needed
   always_ff @(posedge clock) begin
      if (req_xfer && has_result) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

endmodule

// File: rtl/vlpd_checker.sv
// Port-level checks for the varint length-prefix deframer, bound to the top.
// Depends on vlpd_pkg (result codes) and varint_length_prefix_deframer.
module vlpd_assertions (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_byte_in,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_data,
   input logic       rsp_last
);

   // stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_data)
         && $stable(rsp_last))
      else $error("result changed while stalled");

   // no skid buffer: a stalled result blocks new bytes
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("byte taken while result stalled");

   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != vlpd_pkg::KIND_PAYLOAD) |-> rsp_data == 8'd0)
      else $error("nonzero data on non-payload result");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == vlpd_pkg::KIND_EMPTY) |-> rsp_last)
      else $error("empty message without last");

   a_error_no_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_kind == vlpd_pkg::KIND_OVERLONG)
         || (rsp_kind == vlpd_pkg::KIND_TOO_LARGE)) |-> !rsp_last)
      else $error("error result with last set");

endmodule

bind varint_length_prefix_deframer vlpd_assertions u_vlpd_assertions (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_byte_in (req_byte_in),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_kind    (rsp_kind),
   .rsp_data    (rsp_data),
   .rsp_last    (rsp_last)
);

// File: bench/vlpd_checker.sv
// Checker for the varint length-prefix deframer: watches both channels and the
// max_length register port, predicts each result and compares it field by field.
// Depends on vlpd_pkg for result codes, widths and the register's reset value.
`timescale 1ns / 100ps

module vlpd_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [7:0]                 req_byte_in,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [1:0]                 rsp_kind,
   input  logic [7:0]                 rsp_data,
   input  logic                       rsp_last,
   input  logic                       csr_wr_en,
   input  logic [vlpd_pkg::LEN_W-1:0] csr_wr_data,
   output int unsigned                error_count,
   output int unsigned                results_pending,
   output logic                       framing_busy
);

   typedef struct packed {
      vlpd_pkg::kind_type kind;
      logic [7:0]         data;
      logic               last;
   } frame_result_type;

   frame_result_type frame_results_q[$];
   int unsigned      result_index;

   // predicted deframer state
   logic                       in_payload;
   logic [vlpd_pkg::LEN_W-1:0] length_accum;
   logic [vlpd_pkg::CNT_W-1:0] length_bytes;
   logic [vlpd_pkg::LEN_W-1:0] bytes_left;
   logic [vlpd_pkg::LEN_W-1:0] max_length;

   task automatic report_mismatch(input string what);
      $display("[%0t] result %0d: %s", $realtime, result_index, what);
      error_count++;
   endtask

   function automatic void restart_length();
      in_payload   = 1'b0;
      length_accum = '0;
      length_bytes = '0;
   endfunction

   // Advances the predicted state by one byte; returns 1 when a result is due.
   function automatic bit deframe_byte(input logic [7:0] b, output frame_result_type res);
      res = '{kind: vlpd_pkg::KIND_PAYLOAD, data: 8'd0, last: 1'b0};
      if (in_payload) begin
         res.data = b;
         if (bytes_left <= 1) begin
            res.last   = 1'b1;
            bytes_left = '0;
            restart_length();
         end else begin
            bytes_left--;
         end
         return 1'b1;
      end
      // groups 1..4 are 7 bits; group 5 keeps only its low nibble; later ones add nothing
      if (length_bytes < 4)
         length_accum |= vlpd_pkg::LEN_W'(b[6:0]) << (vlpd_pkg::GROUP_BITS * length_bytes);
      else if (length_bytes == 4)
         length_accum |= {b[3:0], 28'd0};
      length_bytes++;
      if (b[vlpd_pkg::CONT_BIT]) begin
         if (length_bytes >= vlpd_pkg::MAX_VARINT_BYTES) begin
            restart_length();
            res.kind = vlpd_pkg::KIND_OVERLONG;
            return 1'b1;
         end
         return 1'b0;
      end
      if (length_accum == 0) begin
         restart_length();
         res.kind = vlpd_pkg::KIND_EMPTY;
         res.last = 1'b1;
         return 1'b1;
      end
      if (length_accum > max_length) begin
         restart_length();
         res.kind = vlpd_pkg::KIND_TOO_LARGE;
         return 1'b1;
      end
      bytes_left   = length_accum;
      length_accum = '0;
      length_bytes = '0;
      in_payload   = 1'b1;
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      frame_result_type got;
      frame_result_type want;
      if (reset) begin
         restart_length();
         bytes_left = '0;
         max_length = vlpd_pkg::MAX_LENGTH_RESET;
         frame_results_q.delete();
      end else begin
         // a result never belongs to a byte taken at the same edge
         if (rsp_valid && rsp_ready) begin
            got = '{kind: vlpd_pkg::kind_type'(rsp_kind), data: rsp_data, last: rsp_last};
            if (frame_results_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result kind %0d data %02h last %0b",
                                         rsp_kind, rsp_data, rsp_last));
            end else begin
               want = frame_results_q.pop_front();
               if (got.kind !== want.kind)
                  report_mismatch($sformatf("kind %0d, predicted %0d", rsp_kind, want.kind));
               if (got.data !== want.data)
                  report_mismatch($sformatf("data %02h, predicted %02h", rsp_data, want.data));
               if (got.last !== want.last)
                  report_mismatch($sformatf("last %0b, predicted %0b", rsp_last, want.last));
            end
            result_index++;
         end
         if (req_valid && req_ready) begin
            if (deframe_byte(req_byte_in, want))
               frame_results_q.push_back(want);
         end
         if (csr_wr_en)
            max_length = csr_wr_data;
      end
      results_pending = frame_results_q.size();
      framing_busy    = in_payload || (length_bytes != 0);
   end

endmodule

// File: bench/varint_length_prefix_deframer_test.sv
// Testbench top for varint_length_prefix_deframer: drives the byte stream, the
// result-side ready and the max_length register, and gives the verdict.
// Depends on vlpd_pkg, the block itself and vlpd_checker.
`timescale 1ns / 100ps

module varint_length_prefix_deframer_test;

   // Longest stretch without any transfer before the run is called hung.
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   // Bytes of random stimulus per phase (8 phases, ~1100 bytes in all).
   localparam int unsigned PHASE_BYTES    = 140;
   localparam int unsigned PHASES         = 8;
   // max_length values above this make random payloads far too long, so
   // such phases use only streams that keep the framing in step.
   localparam logic [vlpd_pkg::LEN_W-1:0] SAFE_MAX = vlpd_pkg::LEN_W'(4096);

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [7:0]                 req_byte_in;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [1:0]                 rsp_kind;
   logic [7:0]                 rsp_data;
   logic                       rsp_last;
   logic                       csr_wr_en;
   logic [vlpd_pkg::LEN_W-1:0] csr_wr_data;

   int unsigned      error_count;
   int unsigned      results_pending;
   logic             framing_busy;

   int unsigned      send_idle_pct;
   int unsigned      recv_stall_pct;
   int unsigned      bytes_sent;
   int unsigned      quiet_cycles;
   logic [vlpd_pkg::LEN_W-1:0] max_len_setting;

   // Register settings per phase, extremes included; the first one keeps
   // the reset value so the directed bytes see it too.
   logic [vlpd_pkg::LEN_W-1:0] phase_max [PHASES] = '{32'd1024, 32'd20, 32'd0,
                                                      32'hFFFF_FFFF, 32'd1, 32'd300,
                                                      32'd7, 32'd1024};
   // Idle patterns: none, sender idle, receiver stalling, both.
   int unsigned      phase_send_idle  [4] = '{0, 71, 0, 34};
   int unsigned      phase_recv_stall [4] = '{0, 0, 71, 34};

   // Directed bytes, reset max_length (1024):
   //   zero length -> empty message
   //   length 1, payload ff
   //   length 2, payloads 00 and 80
   //   length 1025 -> too large
   //   ten continued length bytes -> overlong varint
   //   five bytes, upper bits of the fifth dropped -> length 0 -> empty
   //   five bytes giving ffffffff -> too large
   logic [7:0]       directed_stream [28] = '{
      8'h00,
      8'h01, 8'hFF,
      8'h02, 8'h00, 8'h80,
      8'h81, 8'h08,
      8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
      8'h80, 8'h80, 8'h80, 8'h80, 8'h70,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F
   };

   varint_length_prefix_deframer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_byte_in (req_byte_in),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_kind    (rsp_kind),
      .rsp_data    (rsp_data),
      .rsp_last    (rsp_last),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   vlpd_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_byte_in     (req_byte_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_data        (rsp_data),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .error_count     (error_count),
      .results_pending (results_pending),
      .framing_busy    (framing_busy)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver side: ready is redrawn every cycle at the falling edge.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: any transfer or register write restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("varint_length_prefix_deframer test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Called and returns at a falling edge. Valid is dropped only for an idle
   // gap, so back-to-back bytes keep it high.
   task automatic send_byte(input logic [7:0] value);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   = 1'b1;
      req_byte_in = value;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      bytes_sent++;
   endtask

   // Sender holds off until every predicted result has been taken.
   task automatic drain_results();
      req_valid = 1'b0;
      while (results_pending != 0) @(negedge clock);
   endtask

   // Register writes happen only with the block idle; the short wait after
   // the drain covers a length byte still in the pipe.
   task automatic write_max_length(input logic [vlpd_pkg::LEN_W-1:0] value);
      drain_results();
      repeat (3) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      max_len_setting = value;
   endtask

   // Fewest bytes a varint of this value needs.
   function automatic int unsigned varint_bytes(input logic [vlpd_pkg::LEN_W-1:0] value);
      int unsigned n = 1;
      while (n < 5 && (value >> (vlpd_pkg::GROUP_BITS * n)) != 0) n++;
      return n;
   endfunction

   // Encodes a length in nbytes bytes (padding with zero groups when longer
   // than needed). With filler set, the dropped bits of the fifth byte and
   // every group after it carry random bits, which must not change the value.
   task automatic send_length(input logic [vlpd_pkg::LEN_W-1:0] value,
                              input int unsigned nbytes, input bit filler);
      logic [6:0] group;
      for (int unsigned i = 0; i < nbytes; i++) begin
         if (i < 4)
            group = value[vlpd_pkg::GROUP_BITS*i +: 7];
         else if (i == 4)
            group = {filler ? 3'($urandom) : 3'b000, value[31:28]};
         else
            group = filler ? 7'($urandom) : 7'd0;
         send_byte({i + 1 < nbytes, group});
      end
   endtask

   // One random stretch of stream: mostly complete messages with random
   // payload (short and long varint forms), plus overlong varints, lengths
   // above the limit, cut-short messages and loose noise bytes. The last two
   // throw the framing off, so they are kept to phases with a small limit.
   task automatic send_frame_sequence();
      int unsigned                pick;
      int unsigned                cap;
      int unsigned                nbytes;
      int unsigned                cut;
      logic [vlpd_pkg::LEN_W-1:0] len;
      logic [vlpd_pkg::LEN_W:0]   over;
      bit                         tame;
      tame = max_len_setting <= SAFE_MAX;
      pick = $urandom_range(99);
      cap  = (max_len_setting < 40) ? max_len_setting : 40;
      if ($urandom_range(19) == 0)
         cap = (max_len_setting < 300) ? max_len_setting : 300;
      case ($urandom_range(9))
         0, 1:    len = '0;
         2:       len = cap;           // right at the limit when it is small
         default: len = $urandom_range(cap);
      endcase
      if (pick < 8) begin
         repeat (vlpd_pkg::MAX_VARINT_BYTES) send_byte({1'b1, 7'($urandom)});
      end else if (pick < 18 && max_len_setting != '1) begin
         // just above the limit half the time, anywhere above it otherwise
         over = max_len_setting + 33'd1 + ($urandom_range(1) ? 33'd0 : 33'($urandom));
         if (over[vlpd_pkg::LEN_W])
            over = {1'b0, {vlpd_pkg::LEN_W{1'b1}}};
         len = over[vlpd_pkg::LEN_W-1:0];
         send_length(len, $urandom_range(10, varint_bytes(len)), 1'($urandom_range(1)));
      end else if (tame && pick < 26) begin
         repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
      end else begin
         nbytes = varint_bytes(len);
         if (pick >= 80)
            nbytes = $urandom_range(10, 5);
         else if (pick >= 70)
            nbytes = $urandom_range(10, nbytes);
         send_length(len, nbytes, 1'($urandom_range(1)));
         cut = len;
         if (tame && len != 0 && $urandom_range(9) == 0)
            cut = $urandom_range(len - 1);
         repeat (cut) send_byte(8'($urandom));
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_byte_in     = 8'd0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      bytes_sent      = 0;
      max_len_setting = vlpd_pkg::MAX_LENGTH_RESET;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_stream[i])
         send_byte(directed_stream[i]);

      for (int p = 0; p < PHASES; p++) begin
         write_max_length(phase_max[p]);
         send_idle_pct  = phase_send_idle[p % 4];
         recv_stall_pct = phase_recv_stall[p % 4];
         bytes_sent     = 0;
         while (bytes_sent < PHASE_BYTES) begin
            send_frame_sequence();
            if ($urandom_range(39) == 0)
               drain_results();
         end
         // zero bytes close any open length or message so the next phase
         // starts on a frame boundary
         while (framing_busy)
            send_byte(8'h00);
      end

      drain_results();
      repeat (10) @(negedge clock);
      if (error_count == 0) begin
         $display("varint_length_prefix_deframer test passed");
      end else begin
         $display("varint_length_prefix_deframer test failed");
      end
      $finish;
   end

endmodule
